// ===== design/can_tx_queue_with_id_formatting_defines.svh =====
// Assertion macros shared by the CAN transmit queue modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef CAN_TX_QUEUE_WITH_ID_FORMATTING_DEFINES_SVH
`define CAN_TX_QUEUE_WITH_ID_FORMATTING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTXQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctxq check failed");

// Next-cycle implication, disabled during reset.
`define CTXQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctxq check failed");

`endif

// ===== design/ctxq_pkg.sv =====
// Package for the CAN transmit queue: sizes, command codes and transaction types.
// No dependencies; imported by every module of the block.
package ctxq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int CHANNEL_COUNT = 4;
  localparam int ENTRY_COUNT   = CHANNEL_COUNT * QUEUE_DEPTH;
  localparam int IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int CH_W          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int ADDR_W        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int MID_DEPTH     = 2;
  localparam int MID_PTR_W     = $clog2(MID_DEPTH);
  localparam int MID_CNT_W     = $clog2(MID_DEPTH + 1);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_READY = 1'b1;

  typedef struct packed {
    logic        command;
    logic [1:0]  channel;
    logic [28:0] frame_id;
    logic        extended;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic [2:0]  empty_flags;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        sent;
    logic [2:0]  buffer_select;
    logic [7:0]  id_byte0;
    logic [7:0]  id_byte1;
    logic [7:0]  id_byte2;
    logic [7:0]  id_byte3;
    logic [63:0] data_out;
    logic [3:0]  length_out;
    logic        irq_enable;
  } out_t;

  // One stored frame.
  typedef struct packed {
    logic [3:0]  length;
    logic        extended;
    logic [28:0] id;
    logic [63:0] data;
  } entry_t;

  // Classified transaction handed from front to back.
  typedef struct packed {
    logic        accepted;
    logic        sent;
    logic [2:0]  buffer_select;
    logic        irq_enable;
    entry_t      frame;
  } mid_rec_t;

endpackage

// ===== design/can_tx_queue_with_id_formatting.sv =====
// CAN transmit queue with identifier formatting: top level.
// Depends on ctxq_pkg, ctxq_front, ctxq_mid_fifo and ctxq_back.
//
// Each accepted transaction either pushes a frame onto one of CHANNEL_COUNT
// circular queues (QUEUE_DEPTH frames each) or reports a transmit-ready event
// with the controller's buffer-empty flags; every transaction yields exactly
// one result. A push to a full queue is dropped (accepted = 0) but still sets
// the channel's interrupt enable. A ready event with flag bit 0 pops the head
// frame and returns its identifier packed into the four identifier register
// bytes (standard or extended layout), or clears the interrupt enable when the
// queue is empty. A channel beyond CHANNEL_COUNT yields an all-zero result.
// The input rate is set by the front end's frame memory, which is written or
// read on the accept cycle and whose registered read data is handed on in the
// following cycle; no new transaction is accepted until that hand-over. From
// accept, a result passes the issue state, the mid queue and the result register.
// A two-entry queue between front and back plus the result register let input keep
// flowing while up to three results wait to be popped. No clearing pass is
// needed after reset: only entries between head and tail are ever read.
module can_tx_queue_with_id_formatting (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  ctxq_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output ctxq_pkg::out_t result
);
  import ctxq_pkg::*;

  // Classified transactions travel from front to back through the mid queue.
  logic     mid_full;
  logic     mid_push;
  mid_rec_t mid_wr_rec;
  logic     mid_valid;
  logic     mid_pop;
  mid_rec_t mid_rd_rec;

  // Accept, classify, update pointers and access the frame memory.
  ctxq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_rec  (mid_wr_rec)
  );

  // Hold classified transactions until the back end takes them.
  ctxq_mid_fifo u_mid_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (mid_push),
    .wr_rec     (mid_wr_rec),
    .fifo_full  (mid_full),
    .rd_en      (mid_pop),
    .rd_rec     (mid_rd_rec),
    .fifo_valid (mid_valid)
  );

  // Pack identifier bytes and present the result transaction.
  ctxq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid_rec   (mid_rd_rec),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== design/ctxq_front.sv =====
// Front end: accepts transactions, keeps queue pointers and the frame memory.
// Depends on ctxq_pkg and the shared assertion macros.
`include "can_tx_queue_with_id_formatting_defines.svh"
module ctxq_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ctxq_pkg::in_t      item,
  input  logic               mid_full,
  output logic               mid_push,
  output ctxq_pkg::mid_rec_t mid_rec
);
  import ctxq_pkg::*;

  typedef enum logic [0:0] {S_IDLE, S_ISSUE} state_t;

  state_t            state;
  logic [IDX_W-1:0]  head [CHANNEL_COUNT];
  logic [IDX_W-1:0]  tail [CHANNEL_COUNT];
  logic              qfull [CHANNEL_COUNT];
  logic              txen [CHANNEL_COUNT];
  entry_t            entry_mem [ENTRY_COUNT];
  entry_t            rd_entry;

  logic              pend_accepted;
  logic              pend_sent;
  logic [2:0]        pend_select;
  logic              pend_irq;

  logic              in_fire;
  logic [31:0]       chan_ext;
  logic              ch_ok;
  logic [CH_W-1:0]   ch_idx;
  logic [IDX_W-1:0]  head_sel, tail_sel, head_adv, tail_adv;
  logic              full_sel, txen_sel, q_empty;
  logic              is_push, is_ready, do_store, do_send, do_clear, irq_after;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wr_entry;
  logic              full_consistent;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                  input logic [IDX_W-1:0] idx);
    return ADDR_W'(32'(ch) * QUEUE_DEPTH + 32'(idx));
  endfunction

  assign full    = (state != S_IDLE) || mid_full;
  assign in_fire = push && !full;

  always_comb begin
    chan_ext  = 32'(item.channel);
    ch_ok     = chan_ext < 32'(CHANNEL_COUNT);
    ch_idx    = chan_ext[CH_W-1:0];
    head_sel  = head[ch_idx];
    tail_sel  = tail[ch_idx];
    full_sel  = qfull[ch_idx];
    txen_sel  = txen[ch_idx];
    head_adv  = next_idx(head_sel);
    tail_adv  = next_idx(tail_sel);
    q_empty   = (head_sel == tail_sel) && !full_sel;
    is_push   = ch_ok && (item.command == CMD_PUSH);
    is_ready  = ch_ok && (item.command == CMD_READY) && item.empty_flags[0];
    do_store  = is_push && !full_sel;
    do_send   = is_ready && !q_empty;
    do_clear  = is_ready && q_empty;
    irq_after = is_push ? 1'b1 : (do_clear ? 1'b0 : (ch_ok && txen_sel));
    mem_we    = in_fire && do_store;
    mem_re    = in_fire && do_send;
    waddr     = slot_addr(ch_idx, tail_sel);
    raddr     = slot_addr(ch_idx, head_sel);
    wr_entry.length   = item.frame_length;
    wr_entry.extended = item.extended;
    wr_entry.id       = item.frame_id;
    wr_entry.data     = item.frame_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[waddr] <= wr_entry;
    end
    if (mem_re) begin
      rd_entry <= entry_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        qfull[c] <= 1'b0;
        txen[c]  <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pend_accepted <= do_store;
            pend_sent     <= do_send;
            pend_select   <= do_send ? item.empty_flags : 3'b000;
            pend_irq      <= irq_after;
            if (do_store) begin
              tail[ch_idx] <= tail_adv;
              if (tail_adv == head_sel) begin
                qfull[ch_idx] <= 1'b1;
              end
            end
            if (is_push) begin
              txen[ch_idx] <= 1'b1;
            end
            if (do_clear) begin
              txen[ch_idx] <= 1'b0;
            end
            if (do_send) begin
              head[ch_idx]  <= head_adv;
              qfull[ch_idx] <= 1'b0;
            end
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hand the classified transaction over once the memory read has landed.
  always_comb begin
    mid_push              = (state == S_ISSUE);
    mid_rec.accepted      = pend_accepted;
    mid_rec.sent          = pend_sent;
    mid_rec.buffer_select = pend_select;
    mid_rec.irq_enable    = pend_irq;
    mid_rec.frame         = pend_sent ? rd_entry : '0;
  end

  always_comb begin
    full_consistent = 1'b1;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      if (qfull[c] && (head[c] != tail[c])) begin
        full_consistent = 1'b0;
      end
    end
  end

  `CTXQ_ASSERT_NEXT(a_fire_issue, clk, rst, in_fire, state == S_ISSUE)
  `CTXQ_ASSERT_IMPLY(a_issue_room, clk, rst, state == S_ISSUE, !mid_full)
  `CTXQ_ASSERT_IMPLY(a_full_ptr, clk, rst, 1'b1, full_consistent)

endmodule

// ===== design/ctxq_mid_fifo.sv =====
// Short queue between front and back so each side stalls on its own.
// Depends on ctxq_pkg and the shared assertion macros.
`include "can_tx_queue_with_id_formatting_defines.svh"
module ctxq_mid_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  ctxq_pkg::mid_rec_t wr_rec,
  output logic               fifo_full,
  input  logic               rd_en,
  output ctxq_pkg::mid_rec_t rd_rec,
  output logic               fifo_valid
);
  import ctxq_pkg::*;

  mid_rec_t             slots [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [MID_CNT_W-1:0] count;

  function automatic logic [MID_PTR_W-1:0] bump(input logic [MID_PTR_W-1:0] p);
    return (p == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign fifo_full  = (count == MID_CNT_W'(MID_DEPTH));
  assign fifo_valid = (count != '0);
  assign rd_rec     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `CTXQ_ASSERT_IMPLY(a_no_overflow, clk, rst, wr_en, !fifo_full)
  `CTXQ_ASSERT_IMPLY(a_no_underflow, clk, rst, rd_en, fifo_valid)
  `CTXQ_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= MID_CNT_W'(MID_DEPTH))

endmodule

// ===== design/ctxq_back.sv =====
// Back end: packs the identifier registers and holds the result register.
// Depends on ctxq_pkg.
module ctxq_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               mid_valid,
  input  ctxq_pkg::mid_rec_t mid_rec,
  output logic               mid_pop,
  output logic               empty,
  input  logic               pop,
  output ctxq_pkg::out_t     result
);
  import ctxq_pkg::*;

  logic out_valid;
  out_t out_reg;
  out_t packed_res;

  always_comb begin
    packed_res               = '0;
    packed_res.accepted      = mid_rec.accepted;
    packed_res.sent          = mid_rec.sent;
    packed_res.buffer_select = mid_rec.buffer_select;
    packed_res.irq_enable    = mid_rec.irq_enable;
    if (mid_rec.sent) begin
      packed_res.data_out   = mid_rec.frame.data;
      packed_res.length_out = mid_rec.frame.length;
      if (mid_rec.frame.extended) begin
        // Extended layout: format bit sits at bit 3 of byte 1.
        packed_res.id_byte0 = mid_rec.frame.id[28:21];
        packed_res.id_byte1 = {mid_rec.frame.id[20:18], 2'b01, mid_rec.frame.id[17:15]};
        packed_res.id_byte2 = mid_rec.frame.id[14:7];
        packed_res.id_byte3 = {mid_rec.frame.id[6:0], 1'b0};
      end else begin
        packed_res.id_byte0 = mid_rec.frame.id[10:3];
        packed_res.id_byte1 = {mid_rec.frame.id[2:0], 5'b00000};
      end
    end
  end

  assign mid_pop = mid_valid && (!out_valid || pop);
  assign empty   = !out_valid;
  assign result  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      out_reg <= packed_res;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the CAN transmit queue with identifier formatting.
// Depends on ctxq_pkg and can_tx_queue_with_id_formatting; needs no other files.
`timescale 1ns / 1ps

module tb;
  import ctxq_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int TARGET_ITEMS   = 1100;
  localparam int DRAIN_CYCLES   = 10;    // margin after the last result is checked
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off, well beyond the block's buffering
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake before giving up

  logic clk;
  logic rst   = 1'b1;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  in_t  item  = '0;
  logic full;
  logic empty;
  out_t result;

  can_tx_queue_with_id_formatting u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Queue model: per-channel circular frame stores, head/tail, full flag and
  // transmit interrupt enable. Updated once per accepted input transaction.
  // ---------------------------------------------------------------------------
  entry_t           frame_store [CHANNEL_COUNT][QUEUE_DEPTH];
  logic [IDX_W-1:0] head_ix     [CHANNEL_COUNT];
  logic [IDX_W-1:0] tail_ix     [CHANNEL_COUNT];
  bit               ch_full     [CHANNEL_COUNT];
  bit               ch_irq      [CHANNEL_COUNT];

  in_t  commands_to_send [$];  // stimulus not yet accepted; head is the one on the bus
  out_t awaited_results  [$];  // predicted results, oldest first

  int n_accepted, n_results, n_errors, total_items;
  int n_stored, n_dropped, n_sent, n_irq_cleared, n_full_cycles;
  int phase, send_gap_pct, recv_stall_pct;
  int hold_left, hold_done;

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] ix);
    return (ix == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : ix + 1'b1;
  endfunction

  // Apply one transaction to the model and return the result it must produce.
  function automatic out_t model_queue_op(in_t t);
    out_t   r;
    entry_t f;
    int     ch;
    r  = '0;
    ch = t.channel;
    if (ch >= CHANNEL_COUNT) return r;
    if (t.command == CMD_PUSH) begin
      if (!ch_full[ch]) begin
        f.id       = t.frame_id;
        f.extended = t.extended;
        f.length   = t.frame_length;
        f.data     = t.frame_data;
        frame_store[ch][tail_ix[ch]] = f;
        tail_ix[ch] = next_slot(tail_ix[ch]);
        ch_full[ch] = (tail_ix[ch] == head_ix[ch]);
        r.accepted  = 1'b1;
        n_stored++;
      end else begin
        n_dropped++;
      end
      // a dropped push still arms the interrupt
      ch_irq[ch] = 1'b1;
    end else if (t.empty_flags[0]) begin
      if (head_ix[ch] == tail_ix[ch] && !ch_full[ch]) begin
        ch_irq[ch] = 1'b0;
        n_irq_cleared++;
      end else begin
        f = frame_store[ch][head_ix[ch]];
        r.sent          = 1'b1;
        r.buffer_select = t.empty_flags;
        r.data_out      = f.data;
        r.length_out    = f.length;
        if (f.extended) begin
          r.id_byte0 = f.id[28:21];
          r.id_byte1 = {f.id[20:18], 1'b0, 1'b1, f.id[17:15]};
          r.id_byte2 = f.id[14:7];
          r.id_byte3 = {f.id[6:0], 1'b0};
        end else begin
          r.id_byte0 = f.id[10:3];
          r.id_byte1 = {f.id[2:0], 5'b0};
        end
        head_ix[ch] = next_slot(head_ix[ch]);
        ch_full[ch] = 1'b0;
        n_sent++;
      end
    end
    r.irq_enable = ch_irq[ch];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic in_t frame_of(logic [1:0] ch, logic [28:0] id, logic ext,
                                   logic [3:0] len, logic [63:0] data);
    in_t t;
    t              = '0;
    t.command      = CMD_PUSH;
    t.channel      = ch;
    t.frame_id     = id;
    t.extended     = ext;
    t.frame_length = len;
    t.frame_data   = data;
    t.empty_flags  = 3'($urandom);  // ignored on a push; toggle it anyway
    return t;
  endfunction

  function automatic in_t random_frame(logic [1:0] ch);
    return frame_of(ch, 29'($urandom), 1'($urandom), 4'($urandom), {$urandom, $urandom});
  endfunction

  // Ready event; frame fields carry random junk that the block must ignore.
  function automatic in_t ready_event(logic [1:0] ch, logic [2:0] flags);
    in_t t;
    t             = random_frame(ch);
    t.command     = CMD_READY;
    t.empty_flags = flags;
    return t;
  endfunction

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle phases, chosen by how far the input side has progressed:
  // none, sender gaps, receiver stalls, both, then none again.
  // ---------------------------------------------------------------------------
  always_comb begin
    phase          = (total_items == 0) ? 0 : n_accepted * 5 / total_items;
    send_gap_pct   = (phase == 1) ? 59 : (phase == 3) ? 21 : 0;
    recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 21 : 0;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the head of the command queue; predict on acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && full) n_full_cycles++;
      if (push && !full) begin
        awaited_results.push_back(model_queue_op(item));
        commands_to_send.delete(0);
        n_accepted++;
      end
      // hold a blocked transaction steady; otherwise pick the next one or idle
      if (!(push && full)) begin
        if (commands_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          push <= 1'b1;
          item <= commands_to_send[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each popped result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_results++;
        if (awaited_results.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing expected: expected none, actual %h",
                   $time, result);
        end else begin
          want = awaited_results.pop_front();
          check_field("accepted",      want.accepted,      result.accepted);
          check_field("sent",          want.sent,          result.sent);
          check_field("buffer_select", want.buffer_select, result.buffer_select);
          check_field("id_byte0",      want.id_byte0,      result.id_byte0);
          check_field("id_byte1",      want.id_byte1,      result.id_byte1);
          check_field("id_byte2",      want.id_byte2,      result.id_byte2);
          check_field("id_byte3",      want.id_byte3,      result.id_byte3);
          check_field("data_out",      want.data_out,      result.data_out);
          check_field("length_out",    want.length_out,    result.length_out);
          check_field("irq_enable",    want.irq_enable,    result.irq_enable);
        end
      end
      // Once, at the start of the receiver-stall phase, stop popping long
      // enough for the block to fill up and push back on the sender.
      if (hold_done == 0 && phase == 2) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither side completes a handshake for too long.
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL can_tx_queue_with_id_formatting");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stimulus, release reset, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    int         pick;
    logic [1:0] ch;
    logic [2:0] flags;

    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      head_ix[c] = '0;
      tail_ix[c] = '0;
      ch_full[c] = 1'b0;
      ch_irq[c]  = 1'b0;
    end
    hold_left = 0;
    hold_done = 0;

    // Directed: ready on an empty queue, extreme identifiers in both layouts,
    // ready without flag bit 0, pops with assorted flags, then one channel
    // filled to the brim plus one push that must be dropped.
    commands_to_send.push_back(ready_event(2'd0, 3'b001));
    commands_to_send.push_back(frame_of(2'd0, '1, 1'b0, 4'hf, '1));
    commands_to_send.push_back(frame_of(2'd0, '1, 1'b1, 4'h0, '0));
    commands_to_send.push_back(frame_of(2'd0, '0, 1'b1, 4'h8, 64'h0123_4567_89ab_cdef));
    commands_to_send.push_back(ready_event(2'd0, 3'b000));
    commands_to_send.push_back(ready_event(2'd0, 3'b110));
    commands_to_send.push_back(ready_event(2'd0, 3'b111));
    commands_to_send.push_back(ready_event(2'd0, 3'b001));
    commands_to_send.push_back(ready_event(2'd0, 3'b011));
    commands_to_send.push_back(ready_event(2'd0, 3'b101));
    repeat (QUEUE_DEPTH + 1) commands_to_send.push_back(random_frame(2'd3));

    // Random: push bursts that can overrun a queue, drain bursts that mostly
    // carry flag bit 0, and loose single transactions in between.
    while (commands_to_send.size() < TARGET_ITEMS) begin
      pick = $urandom_range(99);
      ch   = 2'($urandom);
      if (pick < 10) begin
        repeat ($urandom_range(12, 20)) commands_to_send.push_back(random_frame(ch));
      end else if (pick < 30) begin
        repeat ($urandom_range(4, 18)) begin
          flags = 3'($urandom);
          if ($urandom_range(9) != 0) flags[0] = 1'b1;
          commands_to_send.push_back(ready_event(ch, flags));
        end
      end else if ($urandom_range(1) == 0) begin
        commands_to_send.push_back(random_frame(ch));
      end else begin
        commands_to_send.push_back(ready_event(ch, 3'($urandom)));
      end
    end
    total_items = commands_to_send.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (commands_to_send.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions in four channels: %0d frames stored, %0d pushes dropped",
             n_accepted, n_stored, n_dropped);
    $display("on a full queue, %0d frames sent, %0d interrupt clears,", n_sent, n_irq_cleared);
    $display("%0d cycles of input backpressure.", n_full_cycles);
    if (n_errors == 0) begin
      $display("PASS can_tx_queue_with_id_formatting");
    end else begin
      $display("FAIL can_tx_queue_with_id_formatting");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ctxq_pkg.sv
design/ctxq_front.sv
design/ctxq_mid_fifo.sv
design/ctxq_back.sv
design/can_tx_queue_with_id_formatting.sv
tb/sv/tb.sv
